### design/cosr_pkg.sv
// Package of the copy-on-write overlay sector redirect block.
// Field widths, register indexes, result codes, sequencer states and the result type.
// No dependencies; compile first.
package cosr_pkg;

  localparam int unsigned START_W    = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned OUTSEC_W   = 25;
  localparam int unsigned BLOCK_W    = 16;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned DOFF_W     = 24;
  localparam int unsigned MOFF_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // The map is stored as 64-bit words, one bit per sector.
  localparam int unsigned WORD_LOG2 = 6;
  localparam int unsigned WORD_BITS = 64;

  // Eight sectors share one byte of the on-disk map.
  localparam int unsigned BYTE_LOG2 = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd9;

  localparam logic FUNC_WRITE     = 1'b1;
  localparam logic KIND_DATA      = 1'b0;
  localparam logic KIND_MAP       = 1'b1;
  localparam logic TARGET_BACKING = 1'b0;
  localparam logic TARGET_OVERLAY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTOR_SHIFT = 2'd0,
    CFG_DATA_OFFSET  = 2'd1,
    CFG_MAP_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_CHK,
    ST_RD1,
    ST_WB0,
    ST_WB1,
    ST_EMB0,
    ST_EMB1,
    ST_EMD
  } state_e;

  typedef struct packed {
    logic                kind;
    logic                target;
    logic [OUTSEC_W-1:0] out_sector;
    logic [BLOCK_W-1:0]  map_block;
    logic                last;
  } res_item_t;

endpackage

### design/cosr_if.sv
// Channel interfaces of the overlay sector redirect block: request, result, config write.
// Depends on cosr_pkg for the payload widths.
interface cosr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [cosr_pkg::START_W-1:0]  start_sector;
  logic [cosr_pkg::COUNT_W-1:0]  sector_count;

  modport source (output valid, func, start_sector, sector_count, input ready);
  modport sink   (input valid, func, start_sector, sector_count, output ready);
endinterface

interface cosr_res_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          target;
  logic [cosr_pkg::OUTSEC_W-1:0] out_sector;
  logic [cosr_pkg::BLOCK_W-1:0]  map_block;
  logic                          last;

  modport source (output valid, kind, target, out_sector, map_block, last, input ready);
  modport sink   (input valid, kind, target, out_sector, map_block, last, output ready);
endinterface

interface cosr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cosr_pkg::CFG_IDX_W-1:0]  index;
  logic [cosr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/cosr_map_ram.sv
// Single-port synchronous RAM holding the written map, one read or write per cycle.
// Read data is registered and holds until the next read. No package dependency.
module cosr_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 64
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cow_overlay_sector_redirect.sv
// Top level of the copy-on-write overlay sector redirect block.
// Depends on cosr_pkg, the interfaces in cosr_if.sv and the map RAM cosr_map_ram.
//
//   channel | modport | payload                                         | transaction
//   req_i   | sink    | func, start_sector, sector_count                | valid && ready
//   res_o   | source  | kind, target, out_sector, map_block, last       | valid && ready
//   cfg_i   | sink    | index, data (sector shift, data/map offsets)    | valid && ready
//
// A read, or any request whose start sector is already in the overlay, issues the map word
// read in the accept cycle; the check state then decides and loads the result once the output register is free.
// A write whose start sector is not yet in the overlay reads both map words and writes both
// back on the single RAM port, then loads up to three results (map blocks, then data).
// After reset the map RAM is cleared one word per cycle, ceil(MAP_SECTORS/64) words capped
// at 1025 (1024 at the default size); no request is accepted meanwhile, config writes are.
// A stalled result sits in the output register; the next request may be accepted meanwhile.
module cow_overlay_sector_redirect #(
  parameter int unsigned MAP_SECTORS = 65536,
  parameter int unsigned MAX_RUN     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cosr_req_if.sink    req_i,
  cosr_res_if.source  res_o,
  cosr_cfg_if.sink    cfg_i
);

  // Map words that a request can ever touch: the start sector is 16 bits wide and a run
  // reaches at most one word past the start's word.
  localparam int unsigned WIDX_W    = cosr_pkg::START_W - cosr_pkg::WORD_LOG2 + 1;
  localparam int unsigned WORDS_ALL = (MAP_SECTORS + cosr_pkg::WORD_BITS - 1)
                                      / cosr_pkg::WORD_BITS;
  localparam int unsigned REACH     = (2 ** (cosr_pkg::START_W - cosr_pkg::WORD_LOG2)) + 1;
  localparam int unsigned DEPTH     = (WORDS_ALL < REACH) ? WORDS_ALL : REACH;
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WIN_W     = 2 * cosr_pkg::WORD_BITS;
  localparam int unsigned SUM_W     = cosr_pkg::START_W + 1;

  // Map block that holds the bit of a sector on the overlay device.
  function automatic logic [cosr_pkg::BLOCK_W-1:0] block_of(
    input logic [cosr_pkg::MOFF_W-1:0]  moff,
    input logic [cosr_pkg::SHIFT_W-1:0] shift,
    input logic [SUM_W-1:0]             sector
  );
    logic [SUM_W-1:0] byte_addr;
    byte_addr = SUM_W'(moff) + (sector >> cosr_pkg::BYTE_LOG2);
    return cosr_pkg::BLOCK_W'(byte_addr >> shift);
  endfunction

  // Configuration registers. The port never stalls; unknown indexes are dropped.
  logic [cosr_pkg::SHIFT_W-1:0] shift_q;
  logic [cosr_pkg::DOFF_W-1:0]  doff_q;
  logic [cosr_pkg::MOFF_W-1:0]  moff_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= cosr_pkg::SHIFT_RESET;
      doff_q  <= '0;
      moff_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cosr_pkg::cfg_idx_e'(cfg_i.index))
        cosr_pkg::CFG_SECTOR_SHIFT: shift_q <= cfg_i.data[cosr_pkg::SHIFT_W-1:0];
        cosr_pkg::CFG_DATA_OFFSET:  doff_q  <= cfg_i.data[cosr_pkg::DOFF_W-1:0];
        cosr_pkg::CFG_MAP_OFFSET:   moff_q  <= cfg_i.data[cosr_pkg::MOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, request fields and working registers.
  cosr_pkg::state_e state_q, state_d;

  logic [AW-1:0]                  clr_cnt_q;
  logic                           func_q;
  logic [cosr_pkg::START_W-1:0]   start_q;
  logic [cosr_pkg::COUNT_W-1:0]   n_q;
  logic [cosr_pkg::WORD_BITS-1:0] word0_q;
  logic [WIN_W-1:0]               new_q;
  logic                           fresh_q;
  logic [cosr_pkg::BLOCK_W-1:0]   blk0_q, blk1_q;

  // Output register: it decouples the sequencer from a stalled result sink.
  logic                  res_vld_q;
  cosr_pkg::res_item_t   res_q;
  logic                  ld;
  cosr_pkg::res_item_t   ld_item;
  logic                  can_load;

  // RAM port.
  logic                           mem_re, mem_we;
  logic [AW-1:0]                  mem_addr;
  logic [cosr_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic req_acc;
  logic clr_done;
  logic in_write;

  cosr_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (cosr_pkg::WORD_BITS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Word indexes of the two map words that a run can touch, and whether they exist.
  logic [WIDX_W-1:0] w0, w1, w_req;
  logic              w0_ok, w1_ok;

  assign w0    = WIDX_W'(start_q >> cosr_pkg::WORD_LOG2);
  assign w1    = w0 + WIDX_W'(1);
  assign w_req = WIDX_W'(req_i.start_sector >> cosr_pkg::WORD_LOG2);
  assign w0_ok = 32'(w0) < DEPTH;
  assign w1_ok = 32'(w1) < DEPTH;

  // The start bit counts only where the sector lies inside the map.
  logic [cosr_pkg::WORD_LOG2-1:0] off;
  logic                           start_in_map;
  logic                           start_hit;

  assign off          = start_q[cosr_pkg::WORD_LOG2-1:0];
  assign start_in_map = cosr_pkg::OUTSEC_W'(start_q) < cosr_pkg::OUTSEC_W'(MAP_SECTORS);
  assign start_hit    = start_in_map && mem_rdata[off];

  // Bits of the two-word window that the run covers and that belong to the map.
  logic [cosr_pkg::START_W-1:0] base;
  logic [WIN_W-1:0]             run_mask, range_mask, set_mask, old_win;

  assign base     = {start_q[cosr_pkg::START_W-1:cosr_pkg::WORD_LOG2],
                     cosr_pkg::WORD_LOG2'(0)};
  assign run_mask = ((WIN_W'(1) << n_q) - WIN_W'(1)) << off;

  always_comb begin
    for (int j = 0; j < WIN_W; j++) begin
      range_mask[j] = (cosr_pkg::OUTSEC_W'(base) + cosr_pkg::OUTSEC_W'(j))
                      < cosr_pkg::OUTSEC_W'(MAP_SECTORS);
    end
  end

  assign set_mask = run_mask & range_mask;
  assign old_win  = {mem_rdata, word0_q};

  logic [SUM_W-1:0]              last_sector;
  logic [cosr_pkg::OUTSEC_W-1:0] ovl_sector;

  assign last_sector = SUM_W'(start_q) + SUM_W'(n_q) - SUM_W'(1);
  assign ovl_sector  = cosr_pkg::OUTSEC_W'(start_q) + cosr_pkg::OUTSEC_W'(doff_q);

  assign req_acc  = req_i.valid && req_i.ready;
  assign clr_done = clr_cnt_q == AW'(DEPTH - 1);
  assign can_load = !res_vld_q || res_o.ready;
  assign in_write = func_q == cosr_pkg::FUNC_WRITE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cosr_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cosr_pkg::ST_CLR:  if (clr_done) state_d = cosr_pkg::ST_IDLE;
      cosr_pkg::ST_IDLE: if (req_acc) state_d = cosr_pkg::ST_CHK;
      cosr_pkg::ST_CHK: begin
        if (start_hit || !in_write) begin
          if (can_load) state_d = cosr_pkg::ST_IDLE;
        end else begin
          state_d = cosr_pkg::ST_RD1;
        end
      end
      cosr_pkg::ST_RD1:  state_d = cosr_pkg::ST_WB0;
      cosr_pkg::ST_WB0:  state_d = cosr_pkg::ST_WB1;
      cosr_pkg::ST_WB1:  state_d = fresh_q ? cosr_pkg::ST_EMB0 : cosr_pkg::ST_EMD;
      cosr_pkg::ST_EMB0: begin
        if (can_load) begin
          state_d = (blk1_q != blk0_q) ? cosr_pkg::ST_EMB1 : cosr_pkg::ST_EMD;
        end
      end
      cosr_pkg::ST_EMB1: if (can_load) state_d = cosr_pkg::ST_EMD;
      cosr_pkg::ST_EMD:  if (can_load) state_d = cosr_pkg::ST_IDLE;
      default:           state_d = cosr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM port, request ready and the result to load.
  always_comb begin
    req_i.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = w0[AW-1:0];
    mem_wdata   = new_q[cosr_pkg::WORD_BITS-1:0];
    ld          = 1'b0;
    ld_item     = '{kind: cosr_pkg::KIND_DATA, target: cosr_pkg::TARGET_OVERLAY,
                    out_sector: ovl_sector, map_block: '0, last: 1'b1};
    unique case (state_q)
      cosr_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      cosr_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_re      = req_acc;
        mem_addr    = w_req[AW-1:0];
      end
      cosr_pkg::ST_CHK: begin
        if (start_hit) begin
          ld = can_load;
        end else if (!in_write) begin
          ld                 = can_load;
          ld_item.target     = cosr_pkg::TARGET_BACKING;
          ld_item.out_sector = cosr_pkg::OUTSEC_W'(start_q);
        end else begin
          mem_re   = 1'b1;
          mem_addr = w1[AW-1:0];
        end
      end
      cosr_pkg::ST_RD1: ;
      cosr_pkg::ST_WB0: begin
        mem_we    = w0_ok;
        mem_addr  = w0[AW-1:0];
        mem_wdata = new_q[cosr_pkg::WORD_BITS-1:0];
      end
      cosr_pkg::ST_WB1: begin
        mem_we    = w1_ok;
        mem_addr  = w1[AW-1:0];
        mem_wdata = new_q[WIN_W-1:cosr_pkg::WORD_BITS];
      end
      cosr_pkg::ST_EMB0: begin
        ld      = can_load;
        ld_item = '{kind: cosr_pkg::KIND_MAP, target: cosr_pkg::TARGET_OVERLAY,
                    out_sector: '0, map_block: blk0_q, last: 1'b0};
      end
      cosr_pkg::ST_EMB1: begin
        ld      = can_load;
        ld_item = '{kind: cosr_pkg::KIND_MAP, target: cosr_pkg::TARGET_OVERLAY,
                    out_sector: '0, map_block: blk1_q, last: 1'b0};
      end
      cosr_pkg::ST_EMD: ld = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (state_q == cosr_pkg::ST_CLR && !clr_done) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Request fields; the run length saturates at MAX_RUN.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      func_q  <= req_i.func;
      start_q <= req_i.start_sector;
      if (32'(req_i.sector_count) > MAX_RUN) begin
        n_q <= cosr_pkg::COUNT_W'(MAX_RUN);
      end else begin
        n_q <= req_i.sector_count;
      end
    end
  end

  // Read-modify-write of the map window. Only one request is in flight, so the write-back
  // of a request always lands before the next request reads the map.
  always_ff @(posedge clk_i) begin
    if (state_q == cosr_pkg::ST_CHK) begin
      word0_q <= mem_rdata;
    end
    if (state_q == cosr_pkg::ST_RD1) begin
      new_q   <= old_win | set_mask;
      fresh_q <= |(set_mask & ~old_win);
      blk0_q  <= block_of(moff_q, shift_q, SUM_W'(start_q));
      blk1_q  <= block_of(moff_q, shift_q, last_sector);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (ld) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      res_q <= ld_item;
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.kind       = res_q.kind;
  assign res_o.target     = res_q.target;
  assign res_o.out_sector = res_q.out_sector;
  assign res_o.map_block  = res_q.map_block;
  assign res_o.last       = res_q.last;

`ifndef ASSERT_OFF
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cosr_pkg::ST_CLR) |-> !res_vld_q)
    else $error("result valid during the map clearing pass");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == cosr_pkg::ST_CLR || state_q == cosr_pkg::ST_WB0 ||
                state_q == cosr_pkg::ST_WB1))
    else $error("map RAM written outside clear or write-back");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == cosr_pkg::ST_CHK))
    else $error("accepted request did not move to the map check");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && ld_item.last) |=> (state_q == cosr_pkg::ST_IDLE))
    else $error("sequencer busy after loading the final result");

  a_map_write_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cosr_pkg::ST_EMB0) |-> fresh_q)
    else $error("map block write without a newly set bit");
`endif

endmodule

### bench/tb_cow_overlay_sector_redirect.sv
`timescale 1ns / 100ps
// Self-checking testbench of cow_overlay_sector_redirect: directed and random requests,
// checked by a scoreboard that keeps its own written map. Needs cosr_pkg, cosr_if.sv and the RTL.
module tb_cow_overlay_sector_redirect;

  // Sizes match the block's default parameters, which the instance below also gets.
  localparam int unsigned MAP_SIZE      = 65536;
  localparam int unsigned RUN_LIMIT     = 16;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned WINDOW_SPAN   = 256;

  // A read has no name in the package, and index 3 maps to no register.
  localparam logic                           FUNC_READ  = 1'b0;
  localparam logic [cosr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // The scoreboard mirrors the block: one bit per sector, the three registers, and the
  // queue of results that accepted requests still owe.
  class redirect_scoreboard;
    bit                           sector_written [MAP_SIZE];
    logic [cosr_pkg::SHIFT_W-1:0] sector_shift;
    logic [cosr_pkg::DOFF_W-1:0]  overlay_base;
    logic [cosr_pkg::MOFF_W-1:0]  map_offset;
    cosr_pkg::res_item_t          owed_results [$];
    int unsigned                  error_count;

    function new();
      sector_shift = cosr_pkg::SHIFT_RESET;
      overlay_base = '0;
      map_offset   = '0;
      error_count  = 0;
    endfunction

    function void apply_register(logic [cosr_pkg::CFG_IDX_W-1:0] idx,
                                 logic [cosr_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        cosr_pkg::CFG_SECTOR_SHIFT: sector_shift = value[cosr_pkg::SHIFT_W-1:0];
        cosr_pkg::CFG_DATA_OFFSET:  overlay_base = value[cosr_pkg::DOFF_W-1:0];
        cosr_pkg::CFG_MAP_OFFSET:   map_offset   = value[cosr_pkg::MOFF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Overlay block that holds the map byte of a sector; sectors past the map still count.
    function logic [cosr_pkg::BLOCK_W-1:0] map_block_of(int unsigned sector);
      int unsigned byte_addr;
      byte_addr = map_offset + (sector >> cosr_pkg::BYTE_LOG2);
      return cosr_pkg::BLOCK_W'(byte_addr >> sector_shift);
    endfunction

    function void owe(logic kind, logic target, logic [cosr_pkg::OUTSEC_W-1:0] sector,
                      logic [cosr_pkg::BLOCK_W-1:0] blk, logic last);
      cosr_pkg::res_item_t r;
      r.kind       = kind;
      r.target     = target;
      r.out_sector = sector;
      r.map_block  = blk;
      r.last       = last;
      owed_results.push_back(r);
    endfunction

    function void note_request(logic func, logic [cosr_pkg::START_W-1:0] start,
                               logic [cosr_pkg::COUNT_W-1:0] count);
      logic [cosr_pkg::OUTSEC_W-1:0] overlay_sector;
      int unsigned                   run;
      int unsigned                   i;
      bit                            fresh;
      logic [cosr_pkg::BLOCK_W-1:0]  first_blk;
      logic [cosr_pkg::BLOCK_W-1:0]  last_blk;
      overlay_sector = cosr_pkg::OUTSEC_W'(start) + cosr_pkg::OUTSEC_W'(overlay_base);
      fresh          = 1'b0;
      if (sector_written[start]) begin
        owe(cosr_pkg::KIND_DATA, cosr_pkg::TARGET_OVERLAY, overlay_sector, '0, 1'b1);
        return;
      end
      if (func != cosr_pkg::FUNC_WRITE) begin
        owe(cosr_pkg::KIND_DATA, cosr_pkg::TARGET_BACKING, cosr_pkg::OUTSEC_W'(start), '0,
            1'b1);
        return;
      end
      run = (count > RUN_LIMIT) ? RUN_LIMIT : count;
      for (i = 0; i < run; i++) begin
        if (start + i < MAP_SIZE && !sector_written[start + i]) begin
          sector_written[start + i] = 1'b1;
          fresh = 1'b1;
        end
      end
      if (fresh) begin
        first_blk = map_block_of(start);
        last_blk  = map_block_of(start + run - 1);
        owe(cosr_pkg::KIND_MAP, cosr_pkg::TARGET_OVERLAY, '0, first_blk, 1'b0);
        if (last_blk != first_blk) begin
          owe(cosr_pkg::KIND_MAP, cosr_pkg::TARGET_OVERLAY, '0, last_blk, 1'b0);
        end
      end
      owe(cosr_pkg::KIND_DATA, cosr_pkg::TARGET_OVERLAY, overlay_sector, '0, 1'b1);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(cosr_pkg::res_item_t seen);
      cosr_pkg::res_item_t want;
      if (owed_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, seen);
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", want.kind, seen.kind);
      compare_field("target", want.target, seen.target);
      compare_field("out_sector", want.out_sector, seen.out_sector);
      compare_field("map_block", want.map_block, seen.map_block);
      compare_field("last", want.last, seen.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cosr_req_if req_ch ();
  cosr_res_if res_ch ();
  cosr_cfg_if cfg_ch ();

  cow_overlay_sector_redirect #(
    .MAP_SECTORS(MAP_SIZE),
    .MAX_RUN    (RUN_LIMIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  redirect_scoreboard sb = new();

  // Idle rates in percent per cycle, changed between phases by the main sequence.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Random requests of a phase cluster in this window so that written sectors get hit.
  int unsigned window_base;
  int unsigned stall_cycles = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  // The result sink stalls at random; a zero rate keeps ready high throughout.
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every transaction is observed here, on the values held just before the edge, so the
  // scoreboard never depends on the order in which processes wake at that edge. The same
  // block runs the watchdog: too many cycles without any transaction end the run.
  always @(posedge clk_i) begin : monitor
    cosr_pkg::res_item_t seen;
    bit                  moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.apply_register(cfg_ch.index, cfg_ch.data);
        moved = 1'b1;
      end
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.func, req_ch.start_sector, req_ch.sector_count);
        moved = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        seen.kind       = res_ch.kind;
        seen.target     = res_ch.target;
        seen.out_sector = res_ch.out_sector;
        seen.map_block  = res_ch.map_block;
        seen.last       = res_ch.last;
        sb.check_result(seen);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid stays high after
  // the transaction, so back-to-back requests never lower and raise it in one step; idle
  // cycles drop it and drive junk payload, which the block must ignore.
  task automatic push_request(input logic func, input logic [cosr_pkg::START_W-1:0] start,
                              input logic [cosr_pkg::COUNT_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid        <= 1'b0;
      req_ch.func         <= 1'($urandom);
      req_ch.start_sector <= cosr_pkg::START_W'($urandom);
      req_ch.sector_count <= cosr_pkg::COUNT_W'($urandom);
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= func;
    req_ch.start_sector <= start;
    req_ch.sector_count <= count;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic cfg_write(input logic [cosr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cosr_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Writes all three registers plus the unused index. Bits above a register's width carry
  // random junk, which the block must drop.
  task automatic program_registers(input logic [cosr_pkg::SHIFT_W-1:0] shift,
                                   input logic [cosr_pkg::DOFF_W-1:0] doff,
                                   input logic [cosr_pkg::MOFF_W-1:0] moff);
    logic [cosr_pkg::CFG_DATA_W-1:0] value;
    cfg_write(CFG_UNUSED, cosr_pkg::CFG_DATA_W'($urandom));
    value = cosr_pkg::CFG_DATA_W'($urandom);
    value[cosr_pkg::SHIFT_W-1:0] = shift;
    cfg_write(cosr_pkg::CFG_SECTOR_SHIFT, value);
    cfg_write(cosr_pkg::CFG_DATA_OFFSET, doff);
    value = cosr_pkg::CFG_DATA_W'($urandom);
    value[cosr_pkg::MOFF_W-1:0] = moff;
    cfg_write(cosr_pkg::CFG_MAP_OFFSET, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the sender back until every owed result has come, then lets the block settle.
  // The first edge makes sure the monitor has noted the last accepted request.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random request. Most land in the phase window, some at the top of the map so that runs
  // spill past its end, some just below a map block boundary so that runs cross it.
  // Counts are mostly legal runs, with empty and oversized runs mixed in.
  function automatic void pick_request(output logic func,
                                       output logic [cosr_pkg::START_W-1:0] start,
                                       output logic [cosr_pkg::COUNT_W-1:0] count);
    int unsigned pick;
    int unsigned step;
    int unsigned boundary;
    pick  = $urandom_range(99);
    func  = 1'($urandom);
    start = cosr_pkg::START_W'($urandom);
    if (pick < 55) begin
      start = cosr_pkg::START_W'(window_base + $urandom_range(WINDOW_SPAN - 1));
    end else if (pick < 70) begin
      start = cosr_pkg::START_W'(MAP_SIZE - 1 - $urandom_range(20));
    end else if (pick < 85) begin
      step     = 32'd1 << sb.sector_shift;
      boundary = (step - sb.map_offset % step) % step
                 + step * $urandom_range(((MAP_SIZE >> cosr_pkg::BYTE_LOG2) - 1) / step);
      boundary = boundary << cosr_pkg::BYTE_LOG2;
      if (boundary >= RUN_LIMIT && boundary <= MAP_SIZE)
        start = cosr_pkg::START_W'(boundary - $urandom_range(RUN_LIMIT - 1, 1));
    end
    pick = $urandom_range(99);
    if (pick < 8) count = '0;
    else if (pick < 18)
      count = cosr_pkg::COUNT_W'($urandom_range((1 << cosr_pkg::COUNT_W) - 1, RUN_LIMIT + 1));
    else count = cosr_pkg::COUNT_W'($urandom_range(RUN_LIMIT, 1));
  endfunction

  // Directed requests with the reset register values: a map block spans 4096 sectors.
  task automatic run_directed();
    push_request(FUNC_READ, 16'd0, 5'd1);                  // read of a clean sector: backing
    push_request(cosr_pkg::FUNC_WRITE, 16'd0, 5'd1);       // first write marks the map
    push_request(FUNC_READ, 16'd0, 5'd1);                  // read of a written sector: overlay
    push_request(cosr_pkg::FUNC_WRITE, 16'd0, 5'd4);       // write starting on a written sector
    push_request(cosr_pkg::FUNC_WRITE, 16'd4090, 5'd16);   // run crosses map blocks 0 and 1
    push_request(cosr_pkg::FUNC_WRITE, 16'd4095, 5'd1);    // inside the previous run
    push_request(cosr_pkg::FUNC_WRITE, 16'd100, 5'd0);     // empty run: data write only
    push_request(FUNC_READ, 16'd100, 5'd1);                // the empty run left the map clean
    push_request(cosr_pkg::FUNC_WRITE, 16'd200, 5'd31);    // oversized run is cut to the limit
    push_request(FUNC_READ, 16'd215, 5'd1);                // last sector of the cut run
    push_request(FUNC_READ, 16'd216, 5'd1);                // first sector past the cut
    push_request(cosr_pkg::FUNC_WRITE, 16'd199, 5'd3);     // only the start sector is fresh
    push_request(cosr_pkg::FUNC_WRITE, 16'd65535, 5'd16);  // run spills past the map end
    push_request(cosr_pkg::FUNC_WRITE, 16'd65535, 5'd1);
    push_request(FUNC_READ, 16'd65535, 5'd16);
    push_request(cosr_pkg::FUNC_WRITE, 16'd65534, 5'd5);
    push_request(FUNC_READ, 16'd65534, 5'd0);
    push_request(cosr_pkg::FUNC_WRITE, 16'd32768, 5'd16);
    push_request(FUNC_READ, 16'd32767, 5'd16);
    push_request(FUNC_READ, 16'd32768, 5'd17);
    push_request(cosr_pkg::FUNC_WRITE, 16'd32760, 5'd16);  // partly written run
  endtask

  initial begin
    logic                         func;
    logic [cosr_pkg::START_W-1:0] start;
    logic [cosr_pkg::COUNT_W-1:0] count;
    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.func         <= 1'b0;
    req_ch.start_sector <= '0;
    req_ch.sector_count <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    send_idle_pct = 30;
    recv_idle_pct = 72;
    window_base   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its map after reset; the first request waits for that.
    run_directed();
    drain_results();

    // Each phase gets its own register setting and idle pattern. The drain between phases
    // is also where the sender holds off until every owed result has been delivered.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 72 : 0;
      recv_idle_pct = (phase < 2) ? 72 : (phase < 4) ? 30 : 0;
      window_base   = $urandom_range(MAP_SIZE - WINDOW_SPAN);
      case (phase)
        0: program_registers(4'd12, 24'hFFFFFF, 16'hFFFF);
        1: program_registers(cosr_pkg::SHIFT_W'($urandom_range(12, 9)),
                             cosr_pkg::DOFF_W'($urandom), cosr_pkg::MOFF_W'($urandom));
        // One-byte map blocks.
        2: program_registers(4'd0, 24'd0, cosr_pkg::MOFF_W'($urandom));
        // Huge map blocks.
        3: program_registers(4'd15, cosr_pkg::DOFF_W'($urandom), 16'd0);
        4: program_registers(cosr_pkg::SHIFT_W'($urandom_range(12, 9)),
                             cosr_pkg::DOFF_W'($urandom), cosr_pkg::MOFF_W'($urandom));
        default: program_registers(cosr_pkg::SHIFT_RESET, 24'd0, 16'd0);
      endcase
      repeat (PHASE_ITEMS) begin
        pick_request(func, start, count);
        push_request(func, start, count);
      end
      drain_results();
    end

    if (sb.error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
